@@ design/plt_pkg.sv @@
// Shared types and constants of the proportional text layout block.
// Used by the front, queue and back modules and the top level.
// Depends on nothing.
package plt_pkg;

    // Width table geometry and glyph range.
    localparam int GLYPH_COUNT = 128;
    localparam int STORE_DEPTH = 128;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int GLYPH_LIMIT = (GLYPH_COUNT < STORE_DEPTH) ? GLYPH_COUNT : STORE_DEPTH;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIXED_WIDTH  = 3'd0,
        CFG_LINE_HEIGHT  = 3'd1,
        CFG_TAB_WIDTH    = 3'd2,
        CFG_PROPORTIONAL = 3'd3,
        CFG_ORIGIN_X     = 3'd4,
        CFG_ORIGIN_Y     = 3'd5
    } t_cfg_idx;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_FLASH   = 8'h66;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] GLYPH_BASE = 8'd32;
    localparam logic [3:0] WHITE_BANK = 4'd7;

    typedef enum logic [2:0] {
        K_WRITE,
        K_GLYPH,
        K_NEWLINE,
        K_TAB,
        K_BAR,
        K_ESC
    } t_kind;

    typedef struct packed {
        logic [7:0]  fixed_width;
        logic [7:0]  line_height;
        logic [10:0] tab_width;
        logic        proportional;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [6:0]  idx;
        logic [7:0]  ew;
        logic        render;
        logic        phase;
        logic        last;
    } t_op;

    typedef struct packed {
        logic        empty;
        logic        full;
    } t_q_status;

    typedef struct packed {
        logic        visible;
        logic [7:0]  glyph_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [3:0]  colour_index;
        logic [7:0]  advance;
        logic [15:0] total_width;
        logic        done_res;
        logic        range_error;
    } t_res;

endpackage

@@ design/plt_in_if.sv @@
// Input channel of the text layout block: valid/ready handshake with the item fields.
// Stand-alone; no package needed.
interface plt_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_code;
    logic [6:0] entry_index;
    logic [7:0] entry_width;
    logic       render;
    logic       flash_phase;
    logic       last;

    modport source (output valid, cmd, char_code, entry_index, entry_width, render,
                    flash_phase, last, input ready);
    modport sink   (input valid, cmd, char_code, entry_index, entry_width, render,
                    flash_phase, last, output ready);
endinterface

@@ design/plt_out_if.sv @@
// Result channel of the text layout block: valid/ready handshake with the result fields.
// Stand-alone; no package needed.
interface plt_out_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [7:0]  glyph_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [3:0]  colour_index;
    logic [7:0]  advance;
    logic [15:0] total_width;
    logic        done_res;
    logic        range_error;

    modport source (output valid, visible, glyph_index, pos_x, pos_y, colour_index, advance,
                    total_width, done_res, range_error, input ready);
    modport sink   (input valid, visible, glyph_index, pos_x, pos_y, colour_index, advance,
                    total_width, done_res, range_error, output ready);
endinterface

@@ design/proportional_text_layout.sv @@
// Top level of the proportional text layout block: configuration registers and assembly
// of front, queue and back. Depends on plt_pkg, plt_in_if, plt_out_if, plt_front,
// plt_queue and plt_back.
//
// Usage: character beats arrive on i_in (valid/ready). A beat with cmd set writes one
// width-table entry and gives no result; any other beat lays out one character and gives
// exactly one result beat on o_out. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata while the block is idle.
// Each character passes the queue and then the output register; a proportional glyph
// also passes the registered width-table read, and a tab waits for its next stop,
// which needs the cursor modulo the tab width from a bit-serial remainder unit that
// takes one restoring step per cursor bit.
// One beat per cycle for table writes, fixed-width glyphs, newlines and escapes while
// the receiver takes each result; the back end takes no new item while a proportional
// glyph waits on its width-table read or a tab on its modulo unit.
// A four-entry queue lets the front keep taking beats while the back end is busy.
// Reset (synchronous, active low) returns the registers to their defaults, empties the
// queue and restarts the string; the width table keeps its contents and must be written
// before a proportional glyph reads it. When the receiver stalls, the result stays in
// the output register and the back end, then the queue, then i_in.ready hold off.
module proportional_text_layout (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    plt_in_if.sink                         i_in,
    plt_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [plt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import plt_pkg::*;

    t_cfg      r_cfg;
    t_op       push_op;
    t_op       head_op;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fixed_width  <= 8'd8;
            r_cfg.line_height  <= 8'd8;
            r_cfg.tab_width    <= 11'd64;
            r_cfg.proportional <= 1'b0;
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIXED_WIDTH:  r_cfg.fixed_width  <= i_cfg_wdata[7:0];
                CFG_LINE_HEIGHT:  r_cfg.line_height  <= i_cfg_wdata[7:0];
                CFG_TAB_WIDTH:    r_cfg.tab_width    <= i_cfg_wdata[10:0];
                CFG_PROPORTIONAL: r_cfg.proportional <= i_cfg_wdata[0];
                CFG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_wdata;
                CFG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The front classifies characters and keeps the escape state.
    plt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qs    (q_status),
        .o_push  (push),
        .o_op    (push_op)
    );

    plt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_qs    (q_status)
    );

    // The back end owns the width table, the layout state and the result register.
    plt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head_op),
        .i_qs    (q_status),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // The queue can never report full and empty together.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    // The back end never takes an item from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // Only the final beat of a string carries a width.
    a_total_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.done_res) |-> (o_out.total_width == '0))
        else $error("total width reported before end of string");

    // A glyph with a range error never advances the cursor.
    a_range_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_error) |-> (o_out.advance == '0))
        else $error("range error with nonzero advance");

endmodule

@@ design/plt_front.sv @@
// Front end: accepts input beats, tracks the escape state and classifies each item.
// Depends on plt_pkg and plt_in_if.
module plt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    plt_in_if.sink             i_in,
    input  plt_pkg::t_q_status i_qs,
    output logic               o_push,
    output plt_pkg::t_op       o_op
);
    import plt_pkg::*;

    logic r_esc;
    logic n_esc;

    assign i_in.ready = !i_qs.full;
    assign o_push     = i_in.valid && !i_qs.full;

    always_comb begin
        o_op.ch     = i_in.char_code;
        o_op.idx    = i_in.entry_index;
        o_op.ew     = i_in.entry_width;
        o_op.render = i_in.render;
        o_op.phase  = i_in.flash_phase;
        o_op.last   = i_in.last;
        n_esc       = r_esc;
        if (i_in.cmd) begin
            o_op.kind = K_WRITE;
        end else if (r_esc) begin
            o_op.kind = K_ESC;
            n_esc     = 1'b0;
        end else if (i_in.char_code == CH_NEWLINE) begin
            o_op.kind = K_NEWLINE;
        end else if (i_in.char_code == CH_TAB) begin
            o_op.kind = K_TAB;
        end else if (i_in.char_code == CH_BAR) begin
            o_op.kind = K_BAR;
            // A bar that ends the string starts no escape.
            n_esc     = !i_in.last;
        end else begin
            o_op.kind = K_GLYPH;
        end
        if (!i_in.cmd && i_in.last) begin
            n_esc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (o_push) begin
            r_esc <= n_esc;
        end
    end

endmodule

@@ design/plt_queue.sv @@
// Short FIFO of classified items between the front and the back.
// Depends on plt_pkg.
module plt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  plt_pkg::t_op       i_op,
    input  logic               i_pop,
    output plt_pkg::t_op       o_head,
    output plt_pkg::t_q_status o_qs
);
    import plt_pkg::*;

    t_op            r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    assign o_head   = r_mem[r_rd];
    assign o_qs.empty = (r_count == '0);
    assign o_qs.full  = (r_count == (QAW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/plt_back.sv @@
// Back end: width table memory, tab modulo unit, layout state and the result register.
// Depends on plt_pkg and plt_out_if.
module plt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plt_pkg::t_cfg      i_cfg,
    input  plt_pkg::t_op       i_head,
    input  plt_pkg::t_q_status i_qs,
    output logic               o_pop,
    plt_out_if.source          o_out
);
    import plt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_TAB
    } t_state;

    t_state      r_state;
    t_op         r_op;
    logic [7:0]  r_width_mem [STORE_DEPTH];
    logic [7:0]  r_mem_rd;
    logic [15:0] r_cursor;
    logic [15:0] r_widest;
    logic [15:0] r_line;
    logic [3:0]  r_colour;
    logic        r_flash;
    logic [15:0] r_divq;
    logic [10:0] r_rem;
    logic [3:0]  r_cnt;
    logic        r_out_valid;
    t_res        r_res;

    t_op         cur;
    logic [7:0]  glyph;
    logic        in_range;
    logic        wr_ok;
    logic        need_read;
    logic        need_div;
    logic        out_free;
    logic        finish;
    logic        mem_we;
    logic [17:0] tab_sum;
    logic [15:0] tab_cursor;
    logic [7:0]  adv;
    logic        rerr;
    logic [16:0] sum_x;
    logic [16:0] sum_y;
    logic [16:0] sum_c;
    logic [16:0] sum_l;
    logic [11:0] rem_sh;
    logic [15:0] fin_cursor;
    logic [15:0] fin_widest;
    logic [15:0] fin_line;
    logic [3:0]  fin_colour;
    logic        fin_flash;
    t_res        fin_res;

    assign out_free = !r_out_valid || o_out.ready;

    // Operand selection, range checks and the finishing arithmetic.
    always_comb begin
        cur       = (r_state == S_IDLE) ? i_head : r_op;
        glyph     = cur.ch - GLYPH_BASE;
        in_range  = ({1'b0, glyph} < 9'(GLYPH_LIMIT));
        wr_ok     = ({2'b00, cur.idx} < 9'(GLYPH_LIMIT));
        need_read = (cur.kind == K_GLYPH) && i_cfg.proportional && in_range;
        need_div  = (cur.kind == K_TAB) && (i_cfg.tab_width != '0);
        tab_sum   = 18'(r_cursor) + 18'(i_cfg.tab_width) - 18'(r_rem);
        if (r_state == S_TAB) begin
            tab_cursor = (|tab_sum[17:16]) ? 16'hFFFF : tab_sum[15:0];
        end else begin
            tab_cursor = r_cursor;
        end
        rerr = 1'b0;
        if (r_state == S_READ) begin
            adv = r_mem_rd;
        end else if (i_cfg.proportional) begin
            adv  = '0;
            rerr = !in_range;
        end else begin
            adv = i_cfg.fixed_width;
        end
        sum_x = 17'(i_cfg.origin_x) + 17'(r_cursor);
        sum_y = 17'(i_cfg.origin_y) + 17'(r_line);
        sum_c = 17'(r_cursor) + 17'(adv);
        sum_l = 17'(r_line) + 17'(i_cfg.line_height);

        fin_cursor = r_cursor;
        fin_widest = r_widest;
        fin_line   = r_line;
        fin_colour = r_colour;
        fin_flash  = r_flash;
        fin_res    = '0;
        unique case (cur.kind)
            K_ESC: begin
                if (cur.ch == CH_FLASH) begin
                    fin_flash = !r_flash;
                end else begin
                    fin_colour = 4'(cur.ch - CH_ZERO);
                end
            end
            K_NEWLINE: begin
                if (r_cursor > r_widest) begin
                    fin_widest = r_cursor;
                end
                fin_cursor = '0;
                fin_line   = sum_l[16] ? 16'hFFFF : sum_l[15:0];
            end
            K_TAB: begin
                fin_cursor = tab_cursor;
            end
            K_GLYPH: begin
                fin_res.glyph_index = glyph;
                fin_res.visible     = cur.render && (!r_flash || cur.phase);
                fin_res.pos_x       = sum_x[16] ? 16'hFFFF : sum_x[15:0];
                fin_res.pos_y       = sum_y[16] ? 16'hFFFF : sum_y[15:0];
                fin_res.advance     = adv;
                fin_res.range_error = rerr;
                fin_cursor          = sum_c[16] ? 16'hFFFF : sum_c[15:0];
            end
            default: begin
            end
        endcase
        fin_res.colour_index = fin_colour;
        fin_res.done_res     = cur.last;
        if (cur.last) begin
            fin_res.total_width = (fin_cursor > fin_widest) ? fin_cursor : fin_widest;
            fin_cursor = '0;
            fin_widest = '0;
            fin_line   = '0;
            fin_colour = WHITE_BANK;
            fin_flash  = 1'b0;
        end
    end

    // Sequencing: which head item leaves the queue and when a result is produced.
    always_comb begin
        o_pop  = 1'b0;
        finish = 1'b0;
        mem_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qs.empty) begin
                    if (cur.kind == K_WRITE) begin
                        o_pop  = 1'b1;
                        mem_we = wr_ok;
                    end else if (need_read || need_div) begin
                        o_pop = 1'b1;
                    end else if (out_free) begin
                        o_pop  = 1'b1;
                        finish = 1'b1;
                    end
                end
            end
            S_READ, S_TAB: begin
                finish = out_free;
            end
            default: begin
            end
        endcase
    end

    assign rem_sh = {r_rem, r_divq[15]};

    // Width table; read data is registered.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_width_mem[cur.idx[STORE_AW-1:0]] <= cur.ew;
        end
        if (o_pop && need_read) begin
            r_mem_rd <= r_width_mem[glyph[STORE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_widest    <= '0;
            r_line      <= '0;
            r_colour    <= WHITE_BANK;
            r_flash     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_cursor    <= fin_cursor;
                r_widest    <= fin_widest;
                r_line      <= fin_line;
                r_colour    <= fin_colour;
                r_flash     <= fin_flash;
                r_res       <= fin_res;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && need_read) begin
                        r_op    <= i_head;
                        r_state <= S_READ;
                    end else if (o_pop && need_div) begin
                        r_op    <= i_head;
                        r_divq  <= r_cursor;
                        r_rem   <= '0;
                        r_cnt   <= '1;
                        r_state <= S_DIV;
                    end
                end
                S_READ, S_TAB: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    // One restoring step of cursor modulo tab width per cycle.
                    if (rem_sh >= {1'b0, i_cfg.tab_width}) begin
                        r_rem <= 11'(rem_sh - {1'b0, i_cfg.tab_width});
                    end else begin
                        r_rem <= rem_sh[10:0];
                    end
                    r_divq <= {r_divq[14:0], 1'b0};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_TAB;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.visible      = r_res.visible;
    assign o_out.glyph_index  = r_res.glyph_index;
    assign o_out.pos_x        = r_res.pos_x;
    assign o_out.pos_y        = r_res.pos_y;
    assign o_out.colour_index = r_res.colour_index;
    assign o_out.advance      = r_res.advance;
    assign o_out.total_width  = r_res.total_width;
    assign o_out.done_res     = r_res.done_res;
    assign o_out.range_error  = r_res.range_error;

endmodule
